// File: rtl/ort_pkg.sv
package ort_pkg;

    localparam int TABLE_SLOTS_D = 64;
    localparam int PEER_COUNT_D  = 64;
    localparam int BLOCK_BITS_D  = 32;
    localparam int TIME_BITS_D   = 32;

    localparam int CNT_W = 7;

    localparam logic [2:0] K_ADD      = 3'd0;
    localparam logic [2:0] K_RM_PAIR  = 3'd1;
    localparam logic [2:0] K_RM_PEER  = 3'd2;
    localparam logic [2:0] K_RM_BLOCK = 3'd3;
    localparam logic [2:0] K_QUERY    = 3'd4;
    localparam logic [2:0] K_BEFORE   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CNT1,
        S_CNT2,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic pair;
        logic peer;
        logic blk;
        logic older;
    } t_cell_hit;

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + {3'b000, v[k]};
        end
        return s;
    endfunction

endpackage

// File: rtl/ort_cell.sv
module ort_cell
    import ort_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_D,
    parameter int TIME_BITS  = TIME_BITS_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [BLOCK_BITS-1:0] i_block,
    input  logic [5:0]            i_peer,
    input  logic [TIME_BITS-1:0]  i_when,
    input  logic                  i_free_before,
    output logic                  o_free_before,
    output logic                  o_first_free,
    output t_cell_hit             o_hit,
    output logic [BLOCK_BITS-1:0] o_block,
    output logic [5:0]            o_peer
);

    logic                  r_valid;
    logic [BLOCK_BITS-1:0] r_block;
    logic [5:0]            r_peer;
    logic [TIME_BITS-1:0]  r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_block <= i_block;
            r_peer  <= i_peer;
            r_time  <= i_when;
        end
    end

    // pass the free token up the row: the first empty cell claims it
    assign o_first_free  = !r_valid && !i_free_before;
    assign o_free_before = i_free_before || !r_valid;

    always_comb begin
        o_hit.valid = r_valid;
        o_hit.peer  = r_valid && (r_peer == i_peer);
        o_hit.blk   = r_valid && (r_block == i_block);
        o_hit.pair  = o_hit.peer && o_hit.blk;
        o_hit.older = r_valid && (r_time < i_when);
    end

    assign o_block = r_block;
    assign o_peer  = r_peer;

endmodule

// File: rtl/outstanding_request_table.sv
// Each accepted word passes S_EVAL, S_CNT1 and S_CNT2 before its first result word in S_EMIT.
// A list operation gives one result word per cycle while the receiver does not stall,
// one per matching slot, or a single word when none match. One item at a time:
// no new word is taken until the last result word of the item is accepted.
// All slot compares run in parallel in the row of cells; the counts pass a
// two-stage popcount tree. Reset clears every slot valid bit at once.
module outstanding_request_table
    import ort_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_D,
    parameter int PEER_COUNT  = PEER_COUNT_D,
    parameter int BLOCK_BITS  = BLOCK_BITS_D,
    parameter int TIME_BITS   = TIME_BITS_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_kind,
    input  logic [31:0]      i_block,
    input  logic [5:0]       i_peer,
    input  logic [31:0]      i_when,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic             o_has_item,
    output logic [31:0]      o_item_block,
    output logic [5:0]       o_item_peer,
    output logic [CNT_W-1:0] o_block_count,
    output logic [CNT_W-1:0] o_peer_count,
    output logic [CNT_W-1:0] o_total_count,
    output logic             o_last
);

    localparam int NG = (TABLE_SLOTS + 7) / 8;

    t_state r_state, n_state;

    logic [2:0]            r_kind;
    logic [BLOCK_BITS-1:0] r_block;
    logic [5:0]            r_peer;
    logic [TIME_BITS-1:0]  r_when;
    logic [TABLE_SLOTS-1:0] r_pend, n_pend;
    logic [1:0]            r_stat, n_stat;

    logic [3:0] r_grp_b [NG];
    logic [3:0] r_grp_p [NG];
    logic [3:0] r_grp_v [NG];
    logic [CNT_W-1:0] r_cnt_b, r_cnt_p, r_cnt_v;

    t_cell_ctl             ctl     [TABLE_SLOTS];
    t_cell_hit             hit     [TABLE_SLOTS];
    logic [BLOCK_BITS-1:0] c_block [TABLE_SLOTS];
    logic [5:0]            c_peer  [TABLE_SLOTS];
    logic [TABLE_SLOTS:0]  free_chain;
    logic [TABLE_SLOTS-1:0] first_free, v_pair, v_peer, v_blk, v_before, v_valid;

    logic [63:0] when_ext;
    logic        in_acc, out_acc, peer_ok, pair_any, add_ok, eval;
    logic [TABLE_SLOTS-1:0] sel_oh;
    logic [31:0] item_blk_ext;
    logic [5:0]  item_peer;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign when_ext = {32'b0, i_when};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_block <= i_block[BLOCK_BITS-1:0];
            r_peer  <= i_peer;
            r_when  <= when_ext[TIME_BITS-1:0];
        end
    end

    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        ort_cell #(
            .BLOCK_BITS (BLOCK_BITS),
            .TIME_BITS  (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl[g]),
            .i_block       (r_block),
            .i_peer        (r_peer),
            .i_when        (r_when),
            .i_free_before (free_chain[g]),
            .o_free_before (free_chain[g+1]),
            .o_first_free  (first_free[g]),
            .o_hit         (hit[g]),
            .o_block       (c_block[g]),
            .o_peer        (c_peer[g])
        );
        assign v_pair[g]   = hit[g].pair;
        assign v_peer[g]   = hit[g].peer;
        assign v_blk[g]    = hit[g].blk;
        assign v_before[g] = hit[g].older;
        assign v_valid[g]  = hit[g].valid;
        assign ctl[g].wr   = eval && add_ok && first_free[g];
        assign ctl[g].clr  = eval && (((r_kind == K_RM_PAIR) && v_pair[g])
                                   || ((r_kind == K_RM_PEER) && v_peer[g])
                                   || ((r_kind == K_RM_BLOCK) && v_blk[g]));
    end

    assign eval     = (r_state == S_EVAL);
    assign peer_ok  = (int'(r_peer) < PEER_COUNT);
    assign pair_any = |v_pair;
    assign add_ok   = (r_kind == K_ADD) && peer_ok && !pair_any && free_chain[TABLE_SLOTS];

    always_comb begin
        n_stat = ST_MISS;
        case (r_kind)
            K_ADD: begin
                if (!peer_ok || pair_any) begin
                    n_stat = ST_MISS;
                end else if (!free_chain[TABLE_SLOTS]) begin
                    n_stat = ST_FULL;
                end else begin
                    n_stat = ST_OK;
                end
            end
            K_QUERY: n_stat = pair_any ? ST_OK : ST_MISS;
            default: n_stat = ST_MISS;
        endcase
    end

    assign sel_oh = r_pend & (~r_pend + {{(TABLE_SLOTS-1){1'b0}}, 1'b1});

    always_comb begin
        n_pend = r_pend;
        if (eval) begin
            case (r_kind)
                K_RM_PAIR:  n_pend = v_pair;
                K_RM_PEER:  n_pend = v_peer;
                K_RM_BLOCK: n_pend = v_blk;
                K_BEFORE:   n_pend = v_before;
                default:    n_pend = '0;
            endcase
        end else if (r_state == S_EMIT && out_acc) begin
            n_pend = r_pend & ~sel_oh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (eval) begin
            r_stat <= n_stat;
        end
    end

    // popcount tree over the updated table
    for (genvar q = 0; q < NG; q++) begin : g_grp
        logic [7:0] gb, gp, gv;
        always_comb begin
            gb = '0;
            gp = '0;
            gv = '0;
            for (int k = 0; k < 8; k++) begin
                if (q * 8 + k < TABLE_SLOTS) begin
                    gb[k] = v_blk[q*8+k];
                    gp[k] = v_peer[q*8+k] && peer_ok;
                    gv[k] = v_valid[q*8+k];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (r_state == S_CNT1) begin
                r_grp_b[q] <= popcnt8(gb);
                r_grp_p[q] <= popcnt8(gp);
                r_grp_v[q] <= popcnt8(gv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CNT_W-1:0] sb, sp, sv;
        sb = '0;
        sp = '0;
        sv = '0;
        for (int q = 0; q < NG; q++) begin
            sb = sb + CNT_W'(r_grp_b[q]);
            sp = sp + CNT_W'(r_grp_p[q]);
            sv = sv + CNT_W'(r_grp_v[q]);
        end
        if (r_state == S_CNT2) begin
            r_cnt_b <= sb;
            r_cnt_p <= sp;
            r_cnt_v <= sv;
        end
    end

    always_comb begin
        item_blk_ext = '0;
        item_peer    = '0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (sel_oh[k]) begin
                item_blk_ext[BLOCK_BITS-1:0] = item_blk_ext[BLOCK_BITS-1:0] | c_block[k];
                item_peer = item_peer | c_peer[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_EVAL;
            S_EVAL: n_state = S_CNT1;
            S_CNT1: n_state = S_CNT2;
            S_CNT2: n_state = S_EMIT;
            S_EMIT: if (out_acc && o_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_stall       = (r_state != S_IDLE);
        o_valid       = (r_state == S_EMIT);
        o_has_item    = |r_pend;
        o_status      = o_has_item ? ST_OK : r_stat;
        o_item_block  = item_blk_ext;
        o_item_peer   = item_peer;
        o_block_count = r_cnt_b;
        o_peer_count  = r_cnt_p;
        o_total_count = r_cnt_v;
        o_last        = ((r_pend & ~sel_oh) == '0);
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while busy");

    a_item_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_item) |-> (o_status == ST_OK))
        else $error("listed entry with bad status");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_total_count) <= TABLE_SLOTS))
        else $error("total beyond table size");

    a_emit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_CNT2))
        else $error("result shown before counts ready");

endmodule

// File: dv/outstanding_request_table_tb.sv
`timescale 1ns / 1ps

module outstanding_request_table_tb;
    import ort_pkg::*;

    localparam int SLOTS = 64;

    typedef struct {
        logic [1:0]  status;
        logic        has_item;
        logic [31:0] item_block;
        logic [5:0]  item_peer;
        logic [6:0]  block_count;
        logic [6:0]  peer_count;
        logic [6:0]  total_count;
        logic        last;
    } t_reply;

    class request_scoreboard;
        bit          busy [SLOTS];
        logic [31:0] blk_of [SLOTS];
        logic [5:0]  peer_of [SLOTS];
        logic [31:0] sent_at [SLOTS];
        int          peer_load [64];
        int          active;
        t_reply      pending [$];
        int          errors;

        function int locate(logic [31:0] b, logic [5:0] p);
            for (int i = 0; i < SLOTS; i++)
                if (busy[i] && blk_of[i] == b && peer_of[i] == p) return i;
            return -1;
        endfunction

        function void vacate(int i);
            busy[i] = 0;
            if (peer_load[peer_of[i]] > 0) peer_load[peer_of[i]]--;
            if (active > 0) active--;
        endfunction

        function void note_request(logic [2:0] k, logic [31:0] b, logic [5:0] p,
                                   logic [31:0] w);
            t_reply rs [$];
            t_reply r;
            int i, f, bc;
            r = '{default: '0};
            r.status = ST_MISS;
            if (k == K_ADD) begin
                if (locate(b, p) < 0) begin
                    f = -1;
                    for (i = 0; i < SLOTS; i++)
                        if (!busy[i]) begin f = i; break; end
                    if (f < 0) r.status = ST_FULL;
                    else begin
                        busy[f] = 1; blk_of[f] = b; peer_of[f] = p; sent_at[f] = w;
                        peer_load[p]++; active++;
                        r.status = ST_OK;
                    end
                end
                rs = {rs, r};
            end else if (k == K_RM_PAIR) begin
                i = locate(b, p);
                if (i >= 0) begin
                    vacate(i);
                    r.status = ST_OK; r.has_item = 1; r.item_block = b; r.item_peer = p;
                end
                rs = {rs, r};
            end else if (k == K_RM_PEER || k == K_RM_BLOCK || k == K_BEFORE) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (busy[i] && ((k == K_RM_PEER && peer_of[i] == p) ||
                                    (k == K_RM_BLOCK && blk_of[i] == b) ||
                                    (k == K_BEFORE && sent_at[i] < w))) begin
                        t_reply h;
                        h = '{default: '0};
                        h.status = ST_OK; h.has_item = 1;
                        h.item_block = blk_of[i]; h.item_peer = peer_of[i];
                        rs = {rs, h};
                        if (k != K_BEFORE) vacate(i);
                    end
                end
                if (rs.size() == 0) rs = {rs, r};
            end else if (k == K_QUERY) begin
                r.status = (locate(b, p) >= 0) ? ST_OK : ST_MISS;
                rs = {rs, r};
            end else
                rs = {rs, r};
            bc = 0;
            for (i = 0; i < SLOTS; i++) if (busy[i] && blk_of[i] == b) bc++;
            foreach (rs[j]) begin
                rs[j].block_count = 7'(bc);
                rs[j].peer_count = 7'(peer_load[p]);
                rs[j].total_count = 7'(active);
                rs[j].last = (j == rs.size() - 1);
                pending = {pending, rs[j]};
            end
        endfunction

        function void check_reply(t_reply a);
            t_reply e;
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++; end
            if (a.has_item !== e.has_item) begin
                $error("has_item exp %0d got %0d", e.has_item, a.has_item); errors++; end
            if (a.item_block !== e.item_block) begin
                $error("item_block exp %0h got %0h", e.item_block, a.item_block); errors++; end
            if (a.item_peer !== e.item_peer) begin
                $error("item_peer exp %0d got %0d", e.item_peer, a.item_peer); errors++; end
            if (a.block_count !== e.block_count) begin
                $error("block_count exp %0d got %0d", e.block_count, a.block_count);
                errors++;
            end
            if (a.peer_count !== e.peer_count) begin
                $error("peer_count exp %0d got %0d", e.peer_count, a.peer_count); errors++; end
            if (a.total_count !== e.total_count) begin
                $error("total_count exp %0d got %0d", e.total_count, a.total_count);
                errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, a.last); errors++; end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_kind = '0;
    logic [31:0] i_block = '0;
    logic [5:0]  i_peer = '0;
    logic [31:0] i_when = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_status;
    logic        o_has_item;
    logic [31:0] o_item_block;
    logic [5:0]  o_item_peer;
    logic [6:0]  o_block_count, o_peer_count, o_total_count;
    logic        o_last;

    request_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    logic [31:0] block_pool [8];

    outstanding_request_table dut (.*);

    always #5 i_clk = ~i_clk;

    // Randomise receiver stalls and check every accepted result word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_reply a;
            a.status = o_status; a.has_item = o_has_item;
            a.item_block = o_item_block; a.item_peer = o_item_peer;
            a.block_count = o_block_count; a.peer_count = o_peer_count;
            a.total_count = o_total_count; a.last = o_last;
            sb.check_reply(a);
        end
        i_stall <= i_rst_n && ($urandom_range(99) < sink_stall_pct);
    end

    // Hold valid after acceptance; the next word or an idle cycle replaces it.
    task automatic send_word(logic [2:0] k, logic [31:0] b, logic [5:0] p, logic [31:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_kind <= k; i_block <= b; i_peer <= p; i_when <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(k, b, p, w);
    endtask

    task automatic random_word();
        int r;
        logic [2:0] k;
        r = $urandom_range(99);
        if (r < 40) k = K_ADD;
        else if (r < 55) k = K_RM_PAIR;
        else if (r < 62) k = K_RM_PEER;
        else if (r < 69) k = K_RM_BLOCK;
        else if (r < 82) k = K_QUERY;
        else if (r < 96) k = K_BEFORE;
        else k = 3'($urandom_range(7, 6));
        send_word(k, ($urandom_range(9) == 0) ? $urandom() : block_pool[$urandom_range(7)],
                  ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(3)),
                  $urandom());
    endtask

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        foreach (block_pool[j]) block_pool[j] = $urandom();
        block_pool[0] = 32'h0; block_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, every kind, duplicates, full table, empty lists.
        send_word(K_QUERY, 0, 0, 0);
        send_word(K_BEFORE, 0, 0, 32'hFFFF_FFFF);
        send_word(K_RM_PEER, 0, 63, 0);
        send_word(K_RM_BLOCK, 32'hFFFF_FFFF, 0, 0);
        send_word(K_RM_PAIR, 0, 0, 0);
        send_word(K_ADD, 0, 0, 0);
        send_word(K_ADD, 0, 0, 5);
        send_word(K_ADD, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF);
        send_word(K_QUERY, 32'hFFFF_FFFF, 63, 0);
        send_word(K_BEFORE, 0, 0, 1);
        send_word(3'd6, 0, 0, 0);
        send_word(3'd7, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF);
        for (int j = 0; j < 63; j++)
            send_word(K_ADD, 32'(j + 1), 6'(j & 3), 32'($urandom()));
        send_word(K_ADD, 32'h1234, 5, 0);
        send_word(K_BEFORE, 0, 0, 32'hFFFF_FFFF);
        send_word(K_RM_BLOCK, 0, 0, 0);
        send_word(K_RM_PEER, 0, 63, 0);
        send_word(K_RM_PAIR, 32'd5, 6'd0, 0);
        send_word(K_ADD, 32'h55, 2, 7);
        send_word(K_BEFORE, 0, 0, 32'h8000_0000);
        for (int j = 0; j < 4; j++) send_word(K_RM_PEER, 0, 6'(j), 0);

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1 || ph == 3) ? 82 : 0;
            sink_stall_pct = (ph == 2 || ph == 3) ? 82 : 0;
            if (ph == 3) begin src_idle_pct = 17; sink_stall_pct = 17; end
            for (int j = 0; j < 10; j++) random_word();
        end
        i_valid <= 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
